### design/bdq_pkg.sv
// Package for the bounded double-ended queue.
// Holds the request codes, status codes, cell command type and default depth.
// No dependencies.
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_DROP_FRONT = 3'd2,
        OP_DROP_BACK  = 3'd3,
        OP_SEARCH     = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell of the row does at a clock edge.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_LOAD,
        CELL_COMPARE,
        CELL_SWEEP
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [VALUE_W-1:0] key;
    } cell_cmd_t;

endpackage

### design/bdq_cell.sv
// One storage cell of the queue row: a held value and a search hit flag.
// Depends on bdq_pkg for the cell command type.
module bdq_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  bdq_pkg::cell_cmd_t                 cmd,
    input  logic                               sel,
    input  logic                               held,
    input  logic [bdq_pkg::VALUE_W-1:0]        value_lo,
    input  logic [bdq_pkg::VALUE_W-1:0]        value_hi,
    input  logic                               hit_hi,
    output logic [bdq_pkg::VALUE_W-1:0]        value,
    output logic                               hit
);

    logic [bdq_pkg::VALUE_W-1:0] value_reg;
    logic [bdq_pkg::VALUE_W-1:0] value_next;
    logic                        hit_reg;
    logic                        hit_next;

    always_comb
    begin
        value_next = value_reg;
        hit_next   = hit_reg;
        unique case (cmd.op)
            bdq_pkg::CELL_HOLD:
            begin
                value_next = value_reg;
            end
            bdq_pkg::CELL_SHIFT_UP:
            begin
                value_next = value_lo;
            end
            bdq_pkg::CELL_SHIFT_DOWN:
            begin
                value_next = value_hi;
            end
            bdq_pkg::CELL_LOAD:
            begin
                if (sel)
                begin
                    value_next = cmd.key;
                end
            end
            bdq_pkg::CELL_COMPARE:
            begin
                hit_next = held && (value_reg == cmd.key);
            end
            bdq_pkg::CELL_SWEEP:
            begin
                // Hit flags move one cell toward the front each cycle.
                hit_next = hit_hi;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign value = value_reg;
    assign hit   = hit_reg;

endmodule

### design/bounded_deque_with_search_top.sv
// Bounded double-ended queue with search, built as a row of DEPTH shifting cells.
// Pushes, drops, unused codes, empty searches: result in the cycle after the beat;
// one beat per cycle while req_stall is low (no sweep, no stalled reply). A search
// otherwise compares held cells, then the hit flags walk down the row to the front.
// Reset (rst_n low, asynchronous) empties the queue; stored values need no clearing.
// Depends on bdq_pkg and bdq_cell.
module bounded_deque_with_search_top
#(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT,
    localparam int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic [bdq_pkg::OP_W-1:0]           operation,
    input  logic signed [bdq_pkg::VALUE_W-1:0] item_value,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output logic [bdq_pkg::STATUS_W-1:0]       status,
    output logic                               found,
    output logic [CNT_W-1:0]                   entry_count
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SWEEP
    } state_t;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    state_t                         state_reg;
    state_t                         state_next;
    logic [CNT_W-1:0]               count_reg;
    logic [CNT_W-1:0]               count_next;
    logic [CNT_W-1:0]               sweep_reg;
    logic [CNT_W-1:0]               sweep_next;
    logic                           hit_acc_reg;
    logic                           hit_acc_next;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    logic [bdq_pkg::STATUS_W-1:0]   status_reg;
    logic [bdq_pkg::STATUS_W-1:0]   status_next;
    logic                           found_reg;
    logic                           found_next;

    logic                           accept;
    bdq_pkg::cell_cmd_t             cmd;
    logic [bdq_pkg::VALUE_W-1:0]    cell_value [DEPTH];
    logic [DEPTH-1:0]               cell_hit;

    assign req_stall = (state_reg != S_IDLE) || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        sweep_next     = sweep_reg;
        hit_acc_next   = hit_acc_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        status_next    = status_reg;
        found_next     = found_reg;
        cmd.op         = bdq_pkg::CELL_HOLD;
        cmd.key        = item_value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next    = bdq_pkg::ST_DONE;
                    found_next     = 1'b0;
                    rsp_valid_next = 1'b1;
                    unique case (operation)
                        bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK:
                        begin
                            if (count_reg == FULL_COUNT)
                            begin
                                status_next = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                                cmd.op = (operation == bdq_pkg::OP_PUSH_FRONT)
                                       ? bdq_pkg::CELL_SHIFT_UP : bdq_pkg::CELL_LOAD;
                            end
                        end
                        bdq_pkg::OP_DROP_FRONT, bdq_pkg::OP_DROP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = bdq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_reg - CNT_W'(1);
                                if (operation == bdq_pkg::OP_DROP_FRONT)
                                begin
                                    cmd.op = bdq_pkg::CELL_SHIFT_DOWN;
                                end
                            end
                        end
                        bdq_pkg::OP_SEARCH:
                        begin
                            // An empty queue answers at once; otherwise sweep the hits.
                            if (count_reg != '0)
                            begin
                                cmd.op         = bdq_pkg::CELL_COMPARE;
                                rsp_valid_next = 1'b0;
                                sweep_next     = count_reg;
                                hit_acc_next   = 1'b0;
                                state_next     = S_SWEEP;
                            end
                        end
                        default:
                        begin
                            status_next = bdq_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            S_SWEEP:
            begin
                cmd.op       = bdq_pkg::CELL_SWEEP;
                hit_acc_next = hit_acc_reg || cell_hit[0];
                sweep_next   = sweep_reg - CNT_W'(1);
                if (sweep_reg == CNT_W'(1))
                begin
                    rsp_valid_next = 1'b1;
                    status_next    = bdq_pkg::ST_DONE;
                    found_next     = hit_acc_reg || cell_hit[0];
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            sweep_reg     <= '0;
            hit_acc_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            status_reg    <= bdq_pkg::ST_DONE;
            found_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            sweep_reg     <= sweep_next;
            hit_acc_reg   <= hit_acc_next;
            rsp_valid_reg <= rsp_valid_next;
            status_reg    <= status_next;
            found_reg     <= found_next;
        end
    end

    // Entry 0 is always the front; the back is entry count - 1.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [bdq_pkg::VALUE_W-1:0] lo;
        logic [bdq_pkg::VALUE_W-1:0] hi;
        logic                        hit_hi;

        if (i == 0)
        begin : g_first
            assign lo = item_value;
        end
        else
        begin : g_mid_lo
            assign lo = cell_value[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign hi     = '0;
            assign hit_hi = 1'b0;
        end
        else
        begin : g_mid_hi
            assign hi     = cell_value[i+1];
            assign hit_hi = cell_hit[i+1];
        end

        bdq_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .sel      (count_reg == CNT_W'(i)),
            .held     (CNT_W'(i) < count_reg),
            .value_lo (lo),
            .value_hi (hi),
            .hit_hi   (hit_hi),
            .value    (cell_value[i]),
            .hit      (cell_hit[i])
        );
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign entry_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("entry count exceeds depth");

    a_full_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bdq_pkg::ST_FULL) |-> entry_count == FULL_COUNT)
        else $error("full status with room left");

    a_empty_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == bdq_pkg::ST_EMPTY) |-> entry_count == '0)
        else $error("empty status with entries held");

    a_found_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && found |-> status == bdq_pkg::ST_DONE && entry_count != '0)
        else $error("found flag on a failed or empty request");

    a_nonsearch_answers: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (operation != bdq_pkg::OP_SEARCH) |=> rsp_valid_reg)
        else $error("non-search beat got no response next cycle");

endmodule

### tb/tb_bounded_deque_with_search_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_with_search_top.
// Depends on bdq_pkg and the block's RTL; a scoreboard class predicts each reply.
module tb_bounded_deque_with_search_top;

    localparam int DEPTH        = bdq_pkg::DEPTH_DEFAULT;
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 2000;
    localparam int STUCK_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam logic [bdq_pkg::OP_W-1:0] OP_LAST_CODE = {bdq_pkg::OP_W{1'b1}};

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_LOOKUP} mix_t;

    typedef struct packed {
        logic [bdq_pkg::STATUS_W-1:0] st;
        logic                         hit;
        logic [CNT_W-1:0]             count;
    } reply_t;

    // Models the queue as a ring buffer and checks each reply against the oldest prediction.
    class deque_tracker;
        logic [bdq_pkg::VALUE_W-1:0] slots [DEPTH];
        int unsigned                 head;
        int unsigned                 held;
        reply_t                      awaited [$];
        int unsigned                 failures;

        function new();
            head     = 0;
            held     = 0;
            failures = 0;
        endfunction

        function void note_request(logic [bdq_pkg::OP_W-1:0] op,
                                   logic [bdq_pkg::VALUE_W-1:0] val);
            reply_t r;
            r.st  = bdq_pkg::ST_DONE;
            r.hit = 1'b0;
            case (op)
                bdq_pkg::OP_PUSH_FRONT:
                    if (held == DEPTH)
                        r.st = bdq_pkg::ST_FULL;
                    else
                    begin
                        head = (head + DEPTH - 1) % DEPTH;
                        slots[head] = val;
                        held++;
                    end
                bdq_pkg::OP_PUSH_BACK:
                    if (held == DEPTH)
                        r.st = bdq_pkg::ST_FULL;
                    else
                    begin
                        slots[(head + held) % DEPTH] = val;
                        held++;
                    end
                bdq_pkg::OP_DROP_FRONT:
                    if (held == 0)
                        r.st = bdq_pkg::ST_EMPTY;
                    else
                    begin
                        head = (head + 1) % DEPTH;
                        held--;
                    end
                bdq_pkg::OP_DROP_BACK:
                    if (held == 0)
                        r.st = bdq_pkg::ST_EMPTY;
                    else
                        held--;
                bdq_pkg::OP_SEARCH:
                    for (int unsigned i = 0; i < held; i++)
                        if (slots[(head + i) % DEPTH] == val)
                            r.hit = 1'b1;
                default:
                    ;
            endcase
            r.count = held[CNT_W-1:0];
            awaited.push_back(r);
        endfunction

        function void check_reply(logic [bdq_pkg::STATUS_W-1:0] st, logic hit,
                                  logic [CNT_W-1:0] count);
            reply_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: reply with nothing outstanding: status %0d found %0d count %0d",
                         $time, st, hit, count);
                failures++;
                return;
            end
            want = awaited.pop_front();
            if (st !== want.st)
            begin
                $display("%0t: status expected %0d, got %0d", $time, want.st, st);
                failures++;
            end
            if (hit !== want.hit)
            begin
                $display("%0t: found expected %0d, got %0d", $time, want.hit, hit);
                failures++;
            end
            if (count !== want.count)
            begin
                $display("%0t: entry_count expected %0d, got %0d", $time, want.count, count);
                failures++;
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function logic [bdq_pkg::VALUE_W-1:0] held_value();
            return slots[(head + $urandom_range(0, held - 1)) % DEPTH];
        endfunction
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               req_valid;
    logic                               req_stall;
    logic [bdq_pkg::OP_W-1:0]           operation;
    logic signed [bdq_pkg::VALUE_W-1:0] item_value;
    logic                               rsp_valid;
    logic                               rsp_stall;
    logic [bdq_pkg::STATUS_W-1:0]       status;
    logic                               found;
    logic [CNT_W-1:0]                   entry_count;

    deque_tracker tracker = new();
    bit           no_idle = 1'b0;
    int unsigned  stuck_cycles = 0;

    bounded_deque_with_search_top #(.DEPTH(DEPTH)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .operation   (operation),
        .item_value  (item_value),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .status      (status),
        .found       (found),
        .entry_count (entry_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Called at a falling edge; returns at the falling edge after the beat.
    task automatic send_request(input logic [bdq_pkg::OP_W-1:0] op,
                                input logic [bdq_pkg::VALUE_W-1:0] val);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0)
        begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid  = 1'b1;
        operation  = op;
        item_value = val;
        do
            @(posedge clk);
        while (req_stall);
        tracker.note_request(op, val);
        @(negedge clk);
    endtask

    function automatic logic [bdq_pkg::OP_W-1:0] pick_op(mix_t mix);
        int unsigned roll;
        logic [bdq_pkg::OP_W-1:0] push_op;
        logic [bdq_pkg::OP_W-1:0] drop_op;
        roll    = $urandom_range(0, 99);
        push_op = $urandom_range(0, 1) ? bdq_pkg::OP_PUSH_FRONT : bdq_pkg::OP_PUSH_BACK;
        drop_op = $urandom_range(0, 1) ? bdq_pkg::OP_DROP_FRONT : bdq_pkg::OP_DROP_BACK;
        case (mix)
            MIX_FILL:
                return roll < 70 ? push_op : (roll < 90 ? bdq_pkg::OP_SEARCH : drop_op);
            MIX_DRAIN:
                return roll < 70 ? drop_op : (roll < 90 ? bdq_pkg::OP_SEARCH : push_op);
            MIX_LOOKUP:
                return roll < 70 ? bdq_pkg::OP_SEARCH : (roll < 85 ? push_op : drop_op);
            default:
            begin
                if (roll < 5)
                    return bdq_pkg::OP_W'($urandom_range(int'(bdq_pkg::OP_SEARCH) + 1,
                                                         int'(OP_LAST_CODE)));
                return roll < 35 ? push_op : (roll < 65 ? drop_op : bdq_pkg::OP_SEARCH);
            end
        endcase
    endfunction

    // Searches mostly look for something held, sometimes one bit away from it.
    function automatic logic [bdq_pkg::VALUE_W-1:0] pick_value(logic [bdq_pkg::OP_W-1:0] op);
        logic [bdq_pkg::VALUE_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom_range(0, 1) ? {1'b1, {(bdq_pkg::VALUE_W-1){1'b0}}}
                                              : {1'b0, {(bdq_pkg::VALUE_W-1){1'b1}}};
            1:       v = $urandom_range(0, 1) ? '0 : '1;
            2:       v = $urandom_range(0, 7);
            default: v = $urandom;
        endcase
        if (op == bdq_pkg::OP_SEARCH && tracker.held != 0 && $urandom_range(0, 2) != 0)
        begin
            v = tracker.held_value();
            if ($urandom_range(0, 3) == 0)
                v ^= 1 << $urandom_range(0, bdq_pkg::VALUE_W - 1);
        end
        return v;
    endfunction

    initial
    begin
        int unsigned sent;
        int unsigned stretch;
        mix_t        mix;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        operation  = bdq_pkg::OP_PUSH_FRONT;
        item_value = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty-queue cases and the unused codes.
        send_request(bdq_pkg::OP_DROP_FRONT, 32'h0000_0001);
        send_request(bdq_pkg::OP_DROP_BACK, 32'hFFFF_FFFF);
        send_request(bdq_pkg::OP_SEARCH, 32'h0000_0000);
        for (int code = int'(bdq_pkg::OP_SEARCH) + 1; code <= int'(OP_LAST_CODE); code++)
            send_request(bdq_pkg::OP_W'(code), $urandom);
        // Extremes on both ends, then hits at the front, middle and back.
        send_request(bdq_pkg::OP_PUSH_FRONT, 32'h8000_0000);
        send_request(bdq_pkg::OP_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(bdq_pkg::OP_PUSH_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::OP_PUSH_BACK, 32'hFFFF_FFFF);
        send_request(bdq_pkg::OP_SEARCH, 32'h0000_0000);
        send_request(bdq_pkg::OP_SEARCH, 32'h8000_0000);
        send_request(bdq_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        send_request(bdq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_request(bdq_pkg::OP_SEARCH, 32'h0000_0001);
        // Drops carry a value that must be ignored; dropped entries stop matching.
        send_request(bdq_pkg::OP_DROP_FRONT, 32'hA5A5_A5A5);
        send_request(bdq_pkg::OP_DROP_BACK, 32'h5A5A_5A5A);
        send_request(bdq_pkg::OP_SEARCH, 32'hFFFF_FFFF);
        send_request(bdq_pkg::OP_SEARCH, 32'h0000_0000);
        send_request(bdq_pkg::OP_DROP_BACK, 32'h0000_0000);
        send_request(bdq_pkg::OP_DROP_FRONT, 32'h0000_0000);
        send_request(bdq_pkg::OP_DROP_FRONT, 32'h0000_0000);

        // Random phases; the first one fills the queue past full.
        sent = 0;
        mix  = MIX_FILL;
        while (sent < RANDOM_ITEMS)
        begin
            stretch = (sent == 0) ? 40 : $urandom_range(8, 40);
            no_idle = ($urandom_range(0, 4) == 0);
            repeat (stretch)
            begin
                logic [bdq_pkg::OP_W-1:0] op;
                op = pick_op(mix);
                send_request(op, pick_value(op));
                sent++;
            end
            mix = mix_t'($urandom_range(0, 3));
        end
        req_valid = 1'b0;
        no_idle   = 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.failures == 0)
            $display("tb_bounded_deque_with_search_top: PASS");
        else
            $display("tb_bounded_deque_with_search_top: FAIL");
        $finish;
    end

    // Reply side: stalls a random number of cycles before taking each beat.
    initial
    begin
        int unsigned hold;
        rsp_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            hold = no_idle ? 0 : $urandom_range(0, 3);
            if (hold != 0)
            begin
                rsp_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall = 1'b0;
            do
                @(posedge clk);
            while (!rsp_valid);
            tracker.check_reply(status, found, entry_count);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, STUCK_LIMIT);
            $display("tb_bounded_deque_with_search_top: FAIL");
            $finish;
        end
    end

endmodule
